// ===== hdl/pepo_pkg.sv =====
// ----------------------------------------------------------------------------
// pepo_pkg - shared types and constants of the path edge point offset unit
// Widths, register codes, turn codes, pipeline payload structs, saturation.
// ----------------------------------------------------------------------------
package pepo_pkg;

  localparam int CW   = 32;        // coordinate width
  localparam int FB   = 16;        // fraction bits (format only)
  localparam int UB   = 30;        // fraction bits of cos / sin
  localparam int NREG = 7;
  localparam int IDXW = 3;
  localparam int MW   = CW + 1;    // magnitude of a difference
  localparam int NW   = UB + 1;    // normalized magnitude width
  localparam int RW   = 32;        // root width
  localparam int QW   = UB + 1;    // quotient width
  localparam int PW   = CW + QW;   // product width
  localparam int SW   = CW + 4;    // width of exact sums
  localparam int SQW  = 64;        // square-root working width
  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS  = QW;

  localparam logic [IDXW-1:0] REG_FRONT_OFF = 3'd0;
  localparam logic [IDXW-1:0] REG_FRONT_WL  = 3'd1;
  localparam logic [IDXW-1:0] REG_FRONT_WR  = 3'd2;
  localparam logic [IDXW-1:0] REG_REAR_OFF  = 3'd3;
  localparam logic [IDXW-1:0] REG_REAR_WL   = 3'd4;
  localparam logic [IDXW-1:0] REG_REAR_WR   = 3'd5;
  localparam logic [IDXW-1:0] REG_MOUNT_H   = 3'd6;

  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // per-item data that rides along the pipeline from the deltas stage on
  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] off;
    logic [CW-1:0] wl;
    logic [CW-1:0] wr;
    logic [CW-1:0] hz;
    logic [1:0]    turn;
    logic          rot;
    logic          sneg;
    logic          dxnz;
  } pl_t;

  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
    logic [NW-1:0]  a;
    logic [NW-1:0]  b;
  } sq_t;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [RW-1:0] rem_c;
    logic [RW-1:0] rem_s;
    logic [QW-1:0] q_c;
    logic [QW-1:0] q_s;
  } dv_t;

  function automatic logic [CW-1:0] sat(input logic [SW-1:0] v);
    logic [CW-1:0] o;
    if (v[SW-1:CW-1] == {(SW-CW+1){1'b0}} || v[SW-1:CW-1] == {(SW-CW+1){1'b1}}) begin
      o = v[CW-1:0];
    end else if (v[SW-1]) begin
      o = {1'b1, {(CW-1){1'b0}}};
    end else begin
      o = {1'b0, {(CW-1){1'b1}}};
    end
    return o;
  endfunction

endpackage

// ===== hdl/pepo_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// pepo_sqrt_cell - one bit step of the integer square root
// Trial-subtracts one root bit and hands remainder and root to the next cell.
// ----------------------------------------------------------------------------
module pepo_sqrt_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  pepo_pkg::pl_t          in_pl,
  input  pepo_pkg::sq_t          in_sq,
  input  logic [pepo_pkg::SQW-1:0] bit_val,
  output logic                   out_vld,
  output pepo_pkg::pl_t          out_pl,
  output pepo_pkg::sq_t          out_sq
);
  import pepo_pkg::*;

  logic          vld_r;
  pl_t           pl_r;
  sq_t           sq_r, sq_nxt;
  logic [SQW-1:0] trial;

  always_comb begin
    trial  = in_sq.res + bit_val;
    sq_nxt = in_sq;
    if (in_sq.n >= trial) begin
      sq_nxt.n   = in_sq.n - trial;
      sq_nxt.res = (in_sq.res >> 1) + bit_val;
    end else begin
      sq_nxt.res = in_sq.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pl_r <= in_pl;
    sq_r <= sq_nxt;
  end

  assign out_vld = vld_r;
  assign out_pl  = pl_r;
  assign out_sq  = sq_r;

endmodule

// ===== hdl/pepo_div_cell.sv =====
// ----------------------------------------------------------------------------
// pepo_div_cell - one quotient bit of the cos and sin divisions
// Restoring step for both quotients against the shared root.
// ----------------------------------------------------------------------------
module pepo_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  pepo_pkg::pl_t in_pl,
  input  pepo_pkg::dv_t in_dv,
  input  logic [1:0]    cin,      // [1] into cos remainder, [0] into sin
  output logic          out_vld,
  output pepo_pkg::pl_t out_pl,
  output pepo_pkg::dv_t out_dv
);
  import pepo_pkg::*;

  logic        vld_r;
  pl_t         pl_r;
  dv_t         dv_r, dv_nxt;
  logic [RW:0] t_c, t_s, den;
  logic        ge_c, ge_s;

  always_comb begin
    den    = {1'b0, in_dv.r};
    t_c    = {in_dv.rem_c, cin[1]};
    t_s    = {in_dv.rem_s, cin[0]};
    ge_c   = t_c >= den;
    ge_s   = t_s >= den;
    dv_nxt = in_dv;
    dv_nxt.rem_c = ge_c ? RW'(t_c - den) : t_c[RW-1:0];
    dv_nxt.rem_s = ge_s ? RW'(t_s - den) : t_s[RW-1:0];
    dv_nxt.q_c   = {in_dv.q_c[QW-2:0], ge_c};
    dv_nxt.q_s   = {in_dv.q_s[QW-2:0], ge_s};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    pl_r <= in_pl;
    dv_r <= dv_nxt;
  end

  assign out_vld = vld_r;
  assign out_pl  = pl_r;
  assign out_dv  = dv_r;

endmodule

// ===== hdl/path_edge_point_offset_unit.sv =====
// ----------------------------------------------------------------------------
// path_edge_point_offset_unit - corridor edge points for a trajectory point
// Rotates the configured half-widths along the path direction on a turn, adds offsets.
// ----------------------------------------------------------------------------
// A new item is taken on every clock (busy stays low). Its result appears on
// the out_ ports at the end of the register chain below, with out_valid high
// for a single cycle. Results come in item order and cannot be held off, so
// the receiver must take each one as it appears.
// The item passes through a chain of 72 registers: the row of 32 square-root
// cells and 31 divider cells, plus nine single stages (capture, deltas,
// leading one, normalize, squares, sum, multiply, round, output).
// Config registers may only be written when no item is in flight.
module path_edge_point_offset_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [pepo_pkg::CW-1:0]   in_here_x,
  input  logic [pepo_pkg::CW-1:0]   in_here_y,
  input  logic [pepo_pkg::CW-1:0]   in_ahead_x,
  input  logic [pepo_pkg::CW-1:0]   in_ahead_y,
  input  logic                      cfg_we,
  input  logic [pepo_pkg::IDXW-1:0] cfg_index,
  input  logic [pepo_pkg::CW-1:0]   cfg_wdata,
  output logic                      out_valid,
  output logic [pepo_pkg::CW-1:0]   out_left_x,
  output logic [pepo_pkg::CW-1:0]   out_left_y,
  output logic [pepo_pkg::CW-1:0]   out_left_z,
  output logic [pepo_pkg::CW-1:0]   out_right_x,
  output logic [pepo_pkg::CW-1:0]   out_right_y,
  output logic [pepo_pkg::CW-1:0]   out_right_z,
  output logic                      out_accepted
);
  import pepo_pkg::*;

  // the pipeline never stalls
  assign busy = 1'b0;

  // ---------------- config registers ----------------
  logic [CW-1:0] cfg_r [NREG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRONT_OFF: cfg_r[REG_FRONT_OFF] <= cfg_wdata;
        REG_FRONT_WL:  cfg_r[REG_FRONT_WL]  <= cfg_wdata;
        REG_FRONT_WR:  cfg_r[REG_FRONT_WR]  <= cfg_wdata;
        REG_REAR_OFF:  cfg_r[REG_REAR_OFF]  <= cfg_wdata;
        REG_REAR_WL:   cfg_r[REG_REAR_WL]   <= cfg_wdata;
        REG_REAR_WR:   cfg_r[REG_REAR_WR]   <= cfg_wdata;
        REG_MOUNT_H:   cfg_r[REG_MOUNT_H]   <= cfg_wdata;
        default: ;  // index past the list: ignored
      endcase
    end
  end

  // ---------------- stage 1: capture item ----------------
  logic          s1_vld_r;
  logic [CW-1:0] s1_px_r, s1_py_r, s1_nx_r, s1_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r <= in_here_x;
    s1_py_r <= in_here_y;
    s1_nx_r <= in_ahead_x;
    s1_ny_r <= in_ahead_y;
  end

  // ---------------- stage 2: deltas, turn class, side select ----------------
  logic signed [CW:0] dx, dy;
  logic [MW-1:0]      a2, b2;
  logic               fwd, py_neg, py_pos, ny_neg, ny_pos, dy_pos, dy_nz;
  pl_t                pl2;

  always_comb begin
    dx     = $signed({s1_nx_r[CW-1], s1_nx_r}) - $signed({s1_px_r[CW-1], s1_px_r});
    dy     = $signed({s1_ny_r[CW-1], s1_ny_r}) - $signed({s1_py_r[CW-1], s1_py_r});
    a2     = dx[CW] ? MW'(-dx) : MW'(dx);
    b2     = dy[CW] ? MW'(-dy) : MW'(dy);
    fwd    = !s1_px_r[CW-1] && (s1_px_r != '0);
    py_neg = s1_py_r[CW-1];
    py_pos = !s1_py_r[CW-1] && (s1_py_r != '0);
    ny_neg = s1_ny_r[CW-1];
    ny_pos = !s1_ny_r[CW-1] && (s1_ny_r != '0);
    dy_nz  = dy != '0;
    dy_pos = !dy[CW] && dy_nz;

    pl2.px  = s1_px_r;
    pl2.py  = s1_py_r;
    pl2.off = fwd ? cfg_r[REG_FRONT_OFF] : cfg_r[REG_REAR_OFF];
    pl2.wl  = fwd ? cfg_r[REG_FRONT_WL]  : cfg_r[REG_REAR_WL];
    pl2.wr  = fwd ? cfg_r[REG_FRONT_WR]  : cfg_r[REG_REAR_WR];
    pl2.hz  = cfg_r[REG_MOUNT_H];
    // same-side y: direction of dy; crossing zero: direction of the crossing
    if ((py_neg && ny_neg) || (py_pos && ny_pos)) begin
      pl2.turn = dy_pos ? TURN_LEFT : TURN_RIGHT;
    end else if (py_neg && ny_pos) begin
      pl2.turn = TURN_LEFT;
    end else if (py_pos && ny_neg) begin
      pl2.turn = TURN_RIGHT;
    end else begin
      pl2.turn = TURN_NONE;
    end
    pl2.rot  = (pl2.turn != TURN_NONE) && dy_nz;
    pl2.dxnz = dx != '0;
    pl2.sneg = pl2.dxnz && (dx[CW] != dy[CW]);
  end

  logic          s2_vld_r;
  pl_t           s2_pl_r;
  logic [MW-1:0] s2_a_r, s2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_pl_r <= pl2;
    s2_a_r  <= a2;
    s2_b_r  <= b2;
  end

  // ---------------- stage 3: leading one of a|b ----------------
  logic [5:0]    pos3;
  logic [MW-1:0] ab3;

  always_comb begin
    ab3  = s2_a_r | s2_b_r;
    pos3 = '0;
    for (int i = 0; i < MW; i++) begin
      if (ab3[i]) pos3 = 6'(i);
    end
  end

  logic          s3_vld_r;
  pl_t           s3_pl_r;
  logic [MW-1:0] s3_a_r, s3_b_r;
  logic [5:0]    s3_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_pl_r  <= s2_pl_r;
    s3_a_r   <= s2_a_r;
    s3_b_r   <= s2_b_r;
    s3_pos_r <= pos3;
  end

  // ---------------- stage 4: normalize larger into [2^30, 2^31) ----------------
  localparam logic [5:0] TOP_POS = 6'(UB);
  logic [NW-1:0] a4, b4;
  logic [63:0]   a_wide, b_wide;

  always_comb begin
    a_wide = 64'(s3_a_r);
    b_wide = 64'(s3_b_r);
    if (s3_pos_r > TOP_POS) begin
      a4 = NW'(a_wide >> (s3_pos_r - TOP_POS));  // dropped bits are truncated
      b4 = NW'(b_wide >> (s3_pos_r - TOP_POS));
    end else begin
      a4 = NW'(a_wide << (TOP_POS - s3_pos_r));
      b4 = NW'(b_wide << (TOP_POS - s3_pos_r));
    end
  end

  logic          s4_vld_r;
  pl_t           s4_pl_r;
  logic [NW-1:0] s4_a_r, s4_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_pl_r <= s3_pl_r;
    s4_a_r  <= a4;
    s4_b_r  <= b4;
  end

  // ---------------- stage 5: squares ----------------
  logic            s5_vld_r;
  pl_t             s5_pl_r;
  logic [NW-1:0]   s5_a_r, s5_b_r;
  logic [2*NW-1:0] s5_aa_r, s5_bb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_pl_r <= s4_pl_r;
    s5_a_r  <= s4_a_r;
    s5_b_r  <= s4_b_r;
    s5_aa_r <= s4_a_r * s4_a_r;
    s5_bb_r <= s4_b_r * s4_b_r;
  end

  // ---------------- stage 6: sum of squares ----------------
  logic s6_vld_r;
  pl_t  s6_pl_r;
  sq_t  s6_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_pl_r     <= s5_pl_r;
    s6_sq_r.n   <= SQW'(s5_aa_r) + SQW'(s5_bb_r);
    s6_sq_r.res <= '0;
    s6_sq_r.a   <= s5_a_r;
    s6_sq_r.b   <= s5_b_r;
  end

  // ---------------- square-root cells: r = floor(sqrt(n)) ----------------
  logic sq_vld [SQRT_CELLS+1];
  pl_t  sq_pl  [SQRT_CELLS+1];
  sq_t  sq_d   [SQRT_CELLS+1];

  assign sq_vld[0] = s6_vld_r;
  assign sq_pl[0]  = s6_pl_r;
  assign sq_d[0]   = s6_sq_r;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    localparam int SH = 2 * (SQRT_CELLS - 1 - i);
    logic [SQW-1:0] bitv;
    assign bitv = SQW'(1) << SH;
    pepo_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (sq_vld[i]),
      .in_pl   (sq_pl[i]),
      .in_sq   (sq_d[i]),
      .bit_val (bitv),
      .out_vld (sq_vld[i+1]),
      .out_pl  (sq_pl[i+1]),
      .out_sq  (sq_d[i+1])
    );
  end

  // ---------------- divider cells: c = b*2^30/r, s = a*2^30/r ----------------
  // The quotient never exceeds 2^30, so the long division starts with
  // b>>1 as partial remainder and shifts in b[0], then zeros.
  logic dv_vld [DIV_CELLS+1];
  pl_t  dv_pl  [DIV_CELLS+1];
  dv_t  dv_d   [DIV_CELLS+1];
  sq_t  sq_last;

  assign sq_last        = sq_d[SQRT_CELLS];
  assign dv_vld[0]      = sq_vld[SQRT_CELLS];
  assign dv_pl[0]       = sq_pl[SQRT_CELLS];
  assign dv_d[0].r      = sq_last.res[RW-1:0];
  assign dv_d[0].rem_c  = RW'(sq_last.b[NW-1:1]);
  assign dv_d[0].rem_s  = RW'(sq_last.a[NW-1:1]);
  assign dv_d[0].q_c    = '0;
  assign dv_d[0].q_s    = '0;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    logic [1:0] cin;
    if (i == 0) begin : g_first
      assign cin = {sq_last.b[0], sq_last.a[0]};
    end else begin : g_rest
      assign cin = 2'b00;
    end
    pepo_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (dv_vld[i]),
      .in_pl   (dv_pl[i]),
      .in_dv   (dv_d[i]),
      .cin     (cin),
      .out_vld (dv_vld[i+1]),
      .out_pl  (dv_pl[i+1]),
      .out_dv  (dv_d[i+1])
    );
  end

  // ---------------- multiply: |width| * c, |width| * s ----------------
  pl_t           pl_m;
  dv_t           dv_m;
  logic [CW-1:0] mag_wl, mag_wr;

  assign pl_m   = dv_pl[DIV_CELLS];
  assign dv_m   = dv_d[DIV_CELLS];
  assign mag_wl = pl_m.wl[CW-1] ? (~pl_m.wl + 1'b1) : pl_m.wl;
  assign mag_wr = pl_m.wr[CW-1] ? (~pl_m.wr + 1'b1) : pl_m.wr;

  logic          m_vld_r;
  pl_t           m_pl_r;
  logic [PW-1:0] m_lc_r, m_rc_r, m_ls_r, m_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= dv_vld[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    m_pl_r <= pl_m;
    m_lc_r <= mag_wl * dv_m.q_c;
    m_rc_r <= mag_wr * dv_m.q_c;
    m_ls_r <= mag_wl * dv_m.q_s;
    m_rs_r <= mag_wr * dv_m.q_s;
  end

  // ---------------- round half away from zero, apply signs ----------------
  localparam logic [PW:0] HALF = (PW+1)'(1) << (UB - 1);

  function automatic logic [SW-1:0] rnd_sgn(input logic [PW-1:0] p, input logic neg);
    logic [PW:0]    s;
    logic [SW-1:0]  m;
    s = {1'b0, p} + HALF;
    m = SW'(s[PW:UB]);
    return neg ? (~m + 1'b1) : m;
  endfunction

  logic          r_vld_r;
  pl_t           r_pl_r;
  logic [SW-1:0] r_lc_r, r_rc_r, r_ls_r, r_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else begin
      r_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    r_pl_r <= m_pl_r;
    r_lc_r <= rnd_sgn(m_lc_r, m_pl_r.wl[CW-1]);
    r_rc_r <= rnd_sgn(m_rc_r, m_pl_r.wr[CW-1]);
    r_ls_r <= rnd_sgn(m_ls_r, m_pl_r.wl[CW-1] ^ m_pl_r.sneg);
    r_rs_r <= rnd_sgn(m_rs_r, m_pl_r.wr[CW-1] ^ m_pl_r.sneg);
  end

  // ---------------- edge points, side check, saturation ----------------
  function automatic logic r_r_sign(input logic [SW-1:0] v);
    return v[SW-1];
  endfunction

  logic signed [SW-1:0] px_s, py_s, off_s, wl_s, wr_s, hz_s;
  logic signed [SW-1:0] lc_s, rc_s, ls_s, rs_s;
  logic signed [SW-1:0] xl, yl, xr, yr;
  logic                 ls_le0, rs_le0, ls_ge0, rs_ge0, reject;

  always_comb begin
    px_s  = SW'($signed(r_pl_r.px));
    py_s  = SW'($signed(r_pl_r.py));
    off_s = SW'($signed(r_pl_r.off));
    wl_s  = SW'($signed(r_pl_r.wl));
    wr_s  = SW'($signed(r_pl_r.wr));
    hz_s  = SW'($signed(r_pl_r.hz));
    lc_s  = $signed(r_lc_r);
    rc_s  = $signed(r_rc_r);
    ls_s  = $signed(r_ls_r);
    rs_s  = $signed(r_rs_r);

    if (r_pl_r.rot && r_pl_r.turn == TURN_RIGHT) begin
      xl = px_s + lc_s;  yl = py_s - ls_s;
      xr = px_s - rc_s;  yr = py_s + rs_s;
    end else if (r_pl_r.rot) begin
      xl = px_s - lc_s;  yl = py_s + ls_s;
      xr = px_s + rc_s;  yr = py_s - rs_s;
    end else begin
      xl = px_s;         yl = py_s + wl_s;
      xr = px_s;         yr = py_s - wr_s;
    end

    ls_le0 = r_r_sign(r_ls_r) || (r_ls_r == '0);
    rs_le0 = r_r_sign(r_rs_r) || (r_rs_r == '0);
    ls_ge0 = !r_r_sign(r_ls_r);
    rs_ge0 = !r_r_sign(r_rs_r);
    // with dx and dy both nonzero, the sine must keep the sign of dx*dy
    reject = r_pl_r.rot && r_pl_r.dxnz &&
             ((!r_pl_r.sneg && (ls_le0 || rs_le0)) ||
              ( r_pl_r.sneg && (ls_ge0 || rs_ge0)));
  end

  logic          out_valid_r;
  logic [CW-1:0] lx_r, ly_r, lz_r, rx_r, ry_r, rz_r;
  logic          acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (reject) begin
      lx_r  <= '0;
      ly_r  <= '0;
      lz_r  <= '0;
      rx_r  <= '0;
      ry_r  <= '0;
      rz_r  <= '0;
      acc_r <= 1'b0;
    end else begin
      lx_r  <= sat(xl + off_s);
      ly_r  <= sat(yl);
      lz_r  <= sat(-hz_s);
      rx_r  <= sat(xr + off_s);
      ry_r  <= sat(yr);
      rz_r  <= sat(-hz_s);
      acc_r <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_left_x   = lx_r;
  assign out_left_y   = ly_r;
  assign out_left_z   = lz_r;
  assign out_right_x  = rx_r;
  assign out_right_y  = ry_r;
  assign out_right_z  = rz_r;
  assign out_accepted = acc_r;

`ifndef SYNTHESIS
  // a rejected item carries all-zero coordinates
  a_reject_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
      out_left_x == '0 && out_left_y == '0 && out_left_z == '0 &&
      out_right_x == '0 && out_right_y == '0 && out_right_z == '0)
    else $error("rejected item with nonzero coordinates");

  // both edge points share the same height
  a_same_z : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_left_z == out_right_z)
    else $error("left and right z differ");

  // cos and sin never exceed one when the rotation is used
  a_unit_bound : assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld[DIV_CELLS] && dv_pl[DIV_CELLS].rot |->
      dv_d[DIV_CELLS].q_c <= (QW'(1) << UB) && dv_d[DIV_CELLS].q_s <= (QW'(1) << UB))
    else $error("cos or sin above one");
`endif

endmodule
